FILE: src/cubemap_sky_gradient_texel_defines.svh
// Assertion macros shared by the sky gradient texel block.
`ifndef CUBEMAP_SKY_GRADIENT_TEXEL_DEFINES_SVH
`define CUBEMAP_SKY_GRADIENT_TEXEL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CSG_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sky gradient texel check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CSG_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sky gradient texel check failed");

`endif

FILE: src/csg_pkg.sv
// Shared types, widths and colour constants of the sky gradient texel block.
package csg_pkg;
	localparam int SIZE_W  = 11;
	localparam int COORD_W = 10;
	localparam int FACE_W  = 3;
	localparam int CH_W    = 8;
	localparam int FRAC    = 16;
	localparam int ONE     = 65536;
	localparam int HALF    = 32768;

	localparam int DEFAULT_MAX_FACE_SIZE = 1024;
	localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(256);

	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int NUM_W       = SIZE_W + FRAC;
	localparam int QMAG_W      = FRAC + 1;
	localparam int SQ_W        = 2 * QMAG_W;
	localparam int ROOT_W      = SQ_W + 1;
	localparam int LEN_W       = QMAG_W;
	localparam int CV_W        = QMAG_W + 1;
	localparam int ROOT_TOP_J  = LEN_W - 1;
	localparam int DIV_TOP_I   = QMAG_W - 1;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = '1;

	localparam int FRONT_STAGES = 4;
	localparam int ROOT_STEPS   = 2;
	localparam int ROOT_STAGES  = 9;
	localparam int DIV_STEPS    = 3;
	localparam int DIV_STAGES   = 6;
	localparam int SHADE_STAGES = 4;
	localparam int ROOT_BASE    = FRONT_STAGES;
	localparam int DIV_BASE     = ROOT_BASE + ROOT_STAGES;
	localparam int SHADE_BASE   = DIV_BASE + DIV_STAGES;
	localparam int NST          = SHADE_BASE + SHADE_STAGES;

	typedef enum logic [FACE_W-1:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	localparam logic signed [CV_W-1:0] COL_ZENITH [3] = '{18'sd6554, 18'sd11796, 18'sd26214};
	localparam logic signed [CV_W-1:0] COL_MID    [3] = '{18'sd55706, 18'sd29491, 18'sd29491};
	localparam logic signed [CV_W-1:0] COL_HORIZ  [3] = '{18'sd65536, 18'sd36045, 18'sd19661};
	localparam logic signed [CV_W-1:0] COL_GROUND [3] = '{18'sd13107, 18'sd7864, 18'sd6554};

	typedef struct packed {
		logic                busy;
		logic [SIZE_W-1:0]   size;
		logic [RECIP_W-1:0]  recip;
	} recip_stat_t;

	typedef struct packed {
		logic                comp_neg;
		logic [QMAG_W-1:0]   comp_mag;
		logic [SQ_W-1:0]     n;
		logic [ROOT_W-1:0]   r;
	} root_t;

	typedef struct packed {
		logic                neg;
		logic [LEN_W-1:0]    len;
		logic [LEN_W-1:0]    rem;
		logic [LEN_W-1:0]    nlow;
		logic [QMAG_W-1:0]   q;
	} quo_t;
endpackage

FILE: src/csg_if.sv
// Channel interfaces of the sky gradient texel block: texel in, colour out, config.
interface csg_in_if;
	import csg_pkg::*;
	logic               valid;
	logic               ready;
	logic [FACE_W-1:0]  face;
	logic [COORD_W-1:0] texel_x;
	logic [COORD_W-1:0] texel_y;
	modport source (output valid, face, texel_x, texel_y, input ready);
	modport sink (input valid, face, texel_x, texel_y, output ready);
endinterface

interface csg_out_if;
	import csg_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] alpha;
	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface csg_cfg_if;
	import csg_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] face_size;
	modport source (output valid, face_size, input ready);
	modport sink (input valid, face_size, output ready);
endinterface

FILE: src/csg_recip.sv
// Face size register and serial reciprocal of the size in use.
module csg_recip #(
	parameter int MAX_FACE_SIZE = csg_pkg::DEFAULT_MAX_FACE_SIZE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  logic [csg_pkg::SIZE_W-1:0] wdata,
	output csg_pkg::recip_stat_t      stat
);
	import csg_pkg::*;

	localparam int CNT_W = $clog2(RECIP_W);
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(RECIP_W - 1);
	localparam logic [RECIP_W-1:0] RESET_RECIP = RECIP_W'((64'(1) << RECIP_SHIFT) / RESET_SIZE);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [SIZE_W-1:0]  wsize;
	logic [SIZE_W:0]    rem_sh;
	logic               qbit;

	always_comb begin
		if (wdata == '0) begin
			wsize = SIZE_W'(1);
		end else if (32'(wdata) > 32'(MAX_FACE_SIZE)) begin
			wsize = SIZE_W'(MAX_FACE_SIZE);
		end else begin
			wsize = wdata;
		end
	end

	// Long division of 2^RECIP_SHIFT by the size: only the top dividend bit is set.
	assign rem_sh = {rem_q, cnt_q == CNT_TOP};
	assign qbit   = rem_sh >= {1'b0, size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			size_q <= RESET_SIZE;
			rem_q  <= '0;
			quo_q  <= RESET_RECIP;
		end else if (we) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_TOP;
			size_q <= wsize;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? SIZE_W'(rem_sh - {1'b0, size_q}) : rem_sh[SIZE_W-1:0];
			quo_q <= {quo_q[RECIP_W-2:0], qbit};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.size  = size_q;
	assign stat.recip = quo_q;
endmodule

FILE: src/csg_front.sv
// Face coordinates u, v by reciprocal multiply, vertical component, sum of squares.
module csg_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [csg_pkg::FRONT_STAGES-1:0]  en,
	input  logic                              acc,
	input  logic [csg_pkg::FACE_W-1:0]        face,
	input  logic [csg_pkg::COORD_W-1:0]       texel_x,
	input  logic [csg_pkg::COORD_W-1:0]       texel_y,
	input  csg_pkg::recip_stat_t              stat,
	output logic [csg_pkg::FRONT_STAGES-1:0]  vld,
	output csg_pkg::root_t                    out_root
);
	import csg_pkg::*;

	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int CHK_W  = QMAG_W + SIZE_W;

	logic [FRONT_STAGES-1:0] vld_q;

	logic [FACE_W-1:0] face_s1, face_s2;
	logic [NUM_W-1:0]  nx_s1, ny_s1, nx_s2, ny_s2;
	logic              negy_s1, negy_s2;
	logic [QMAG_W-1:0] qex_s2, qey_s2;
	logic [QMAG_W-1:0] qx_s3, qy_s3;
	logic              cneg_s3;
	logic [QMAG_W-1:0] cmag_s3;
	root_t             root_s4;

	logic [NUM_W:0]    prep_x, prep_y;
	logic [PROD_W-1:0] px, py;
	logic [QMAG_W-1:0] qx, qy;
	logic              cneg;
	logic [QMAG_W-1:0] cmag;
	logic [SQ_W-1:0]   ssum;

	// Clamp the coordinate, form |2c+1-size| * 2^16 + size/2 and its sign.
	function automatic logic [NUM_W:0] prep(input logic [COORD_W-1:0] c,
			input logic [SIZE_W-1:0] size);
		logic [COORD_W-1:0]     cc;
		logic signed [SIZE_W+1:0] d;
		logic [SIZE_W-1:0]      mag;
		cc  = ({1'b0, c} >= size) ? COORD_W'(size - SIZE_W'(1)) : c;
		d   = $signed({1'b0, cc, 1'b1}) - $signed({1'b0, size});
		mag = (d < 0) ? SIZE_W'(-d) : SIZE_W'(d);
		return {d < 0, {mag, FRAC'(0)} + NUM_W'(size >> 1)};
	endfunction

	// One step of correction: the estimate is low by at most one.
	function automatic logic [QMAG_W-1:0] fix(input logic [NUM_W-1:0] n,
			input logic [QMAG_W-1:0] qe, input logic [SIZE_W-1:0] size);
		logic [CHK_W-1:0] rem;
		rem = CHK_W'(n) - CHK_W'(qe) * CHK_W'(size);
		return (rem >= CHK_W'(size)) ? qe + QMAG_W'(1) : qe;
	endfunction

	always_comb begin
		prep_x = prep(texel_x, stat.size);
		prep_y = prep(texel_y, stat.size);
		px     = PROD_W'(nx_s1) * PROD_W'(stat.recip);
		py     = PROD_W'(ny_s1) * PROD_W'(stat.recip);
		qx     = fix(nx_s2, qex_s2, stat.size);
		qy     = fix(ny_s2, qey_s2, stat.size);
		case (face_s2)
			FACE_PY: begin
				cneg = 1'b0;
				cmag = QMAG_W'(ONE);
			end
			FACE_NY: begin
				cneg = 1'b1;
				cmag = QMAG_W'(ONE);
			end
			FACE_PX, FACE_NX, FACE_PZ, FACE_NZ: begin
				cneg = !negy_s2;
				cmag = qy;
			end
			default: begin
				cneg = 1'b0;
				cmag = '0;
			end
		endcase
		ssum = (SQ_W'(1) << (2 * FRAC)) + SQ_W'(qx_s3) * SQ_W'(qx_s3)
			+ SQ_W'(qy_s3) * SQ_W'(qy_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= acc;
			if (en[1]) vld_q[1] <= vld_q[0];
			if (en[2]) vld_q[2] <= vld_q[1];
			if (en[3]) vld_q[3] <= vld_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			face_s1 <= face;
			nx_s1   <= prep_x[NUM_W-1:0];
			ny_s1   <= prep_y[NUM_W-1:0];
			negy_s1 <= prep_y[NUM_W];
		end
		if (en[1]) begin
			face_s2 <= face_s1;
			nx_s2   <= nx_s1;
			ny_s2   <= ny_s1;
			negy_s2 <= negy_s1;
			qex_s2  <= px[RECIP_SHIFT +: QMAG_W];
			qey_s2  <= py[RECIP_SHIFT +: QMAG_W];
		end
		if (en[2]) begin
			qx_s3   <= qx;
			qy_s3   <= qy;
			cneg_s3 <= cneg;
			cmag_s3 <= cmag;
		end
		if (en[3]) begin
			root_s4.comp_neg <= cneg_s3;
			root_s4.comp_mag <= cmag_s3;
			root_s4.n        <= ssum;
			root_s4.r        <= '0;
		end
	end

	assign vld      = vld_q;
	assign out_root = root_s4;
endmodule

FILE: src/csg_root_stage.sv
// One pipeline stage of the digit-by-digit integer square root.
module csg_root_stage #(
	parameter int FIRST_J = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  csg_pkg::root_t in_root,
	output logic           vld,
	output csg_pkg::root_t out_root
);
	import csg_pkg::*;

	logic  vld_s1;
	root_t root_s1;
	root_t nxt;

	always_comb begin
		logic [ROOT_W-1:0] probe;
		logic [ROOT_W-1:0] trial;
		nxt   = in_root;
		probe = '0;
		trial = '0;
		for (int k = 0; k < ROOT_STEPS; k++) begin
			if (FIRST_J - k >= 0) begin
				probe = ROOT_W'(1) << (2 * (FIRST_J - k));
				trial = nxt.r + probe;
				if ({1'b0, nxt.n} >= trial) begin
					nxt.n = nxt.n - SQ_W'(trial);
					nxt.r = (nxt.r >> 1) + probe;
				end else begin
					nxt.r = nxt.r >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) root_s1 <= nxt;
	end

	assign vld      = vld_s1;
	assign out_root = root_s1;
endmodule

FILE: src/csg_div_stage.sv
// One pipeline stage of the restoring divider that normalizes the vertical component.
module csg_div_stage #(
	parameter int FIRST_I = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  csg_pkg::quo_t in_quo,
	output logic          vld,
	output csg_pkg::quo_t out_quo
);
	import csg_pkg::*;

	logic vld_s1;
	quo_t quo_s1;
	quo_t nxt;

	always_comb begin
		logic [LEN_W:0] sh;
		nxt = in_quo;
		sh  = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (FIRST_I - k >= 0) begin
				sh       = {nxt.rem, nxt.nlow[LEN_W-1]};
				nxt.nlow = nxt.nlow << 1;
				if (sh >= {1'b0, nxt.len}) begin
					nxt.rem = LEN_W'(sh - {1'b0, nxt.len});
					nxt.q   = {nxt.q[QMAG_W-2:0], 1'b1};
				end else begin
					nxt.rem = sh[LEN_W-1:0];
					nxt.q   = {nxt.q[QMAG_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) quo_s1 <= nxt;
	end

	assign vld     = vld_s1;
	assign out_quo = quo_s1;
endmodule

FILE: src/csg_shade.sv
// Gradient blends from the vertical component and conversion to 8-bit channels.
module csg_shade (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [csg_pkg::SHADE_STAGES-1:0]  en,
	input  logic                              in_vld,
	input  csg_pkg::quo_t                     in_quo,
	output logic [csg_pkg::SHADE_STAGES-1:0]  vld,
	output logic [csg_pkg::CH_W-1:0]          red,
	output logic [csg_pkg::CH_W-1:0]          green,
	output logic [csg_pkg::CH_W-1:0]          blue
);
	import csg_pkg::*;

	localparam int T_W = CV_W + CH_W;

	logic [SHADE_STAGES-1:0] vld_q;

	logic                   up_s1;
	logic [QMAG_W-1:0]      w1_s1, mz_s1, mz_s2;
	logic signed [CV_W-1:0] c1_s2 [3];
	logic signed [CV_W-1:0] c2_s3 [3];
	logic [CH_W-1:0]        ch_s4 [3];

	logic [QMAG_W:0]        q2;
	logic [QMAG_W-1:0]      w1, mz;
	logic signed [CV_W-1:0] c1 [3];
	logic signed [CV_W-1:0] c2 [3];
	logic [CH_W-1:0]        ch [3];

	// a + floor(((b-a)*w + half) / one)
	function automatic logic signed [CV_W-1:0] blend(input logic signed [CV_W-1:0] a,
			input logic signed [CV_W-1:0] b, input logic [QMAG_W-1:0] w);
		logic signed [2*CV_W-1:0] p;
		p = (b - a) * $signed({1'b0, w}) + $signed((2*CV_W)'(HALF));
		return a + CV_W'(p >>> FRAC);
	endfunction

	function automatic logic [CH_W-1:0] to_byte(input logic signed [CV_W-1:0] c);
		logic [T_W-1:0]     t;
		logic [T_W-FRAC-1:0] hi;
		t  = {c[CV_W-1:0], CH_W'(0)} - T_W'(c[CV_W-1:0]);
		hi = t[T_W-1:FRAC];
		if (c < 0) return '0;
		return (hi > (T_W-FRAC)'(255)) ? ALPHA_OPAQUE : hi[CH_W-1:0];
	endfunction

	always_comb begin
		q2 = {in_quo.q, 1'b0};
		if (!in_quo.neg) begin
			w1 = (q2 >= (QMAG_W+1)'(ONE)) ? QMAG_W'(ONE) : q2[QMAG_W-1:0];
			mz = (q2 > (QMAG_W+1)'(ONE)) ? QMAG_W'(q2 - (QMAG_W+1)'(ONE)) : '0;
		end else begin
			w1 = in_quo.q;
			mz = '0;
		end
		for (int k = 0; k < 3; k++) begin
			c1[k] = blend(COL_HORIZ[k], up_s1 ? COL_MID[k] : COL_GROUND[k], w1_s1);
			c2[k] = blend(c1_s2[k], COL_ZENITH[k], mz_s2);
			ch[k] = to_byte(c2_s3[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_vld;
			if (en[1]) vld_q[1] <= vld_q[0];
			if (en[2]) vld_q[2] <= vld_q[1];
			if (en[3]) vld_q[3] <= vld_q[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			up_s1 <= !in_quo.neg;
			w1_s1 <= w1;
			mz_s1 <= mz;
		end
		if (en[1]) begin
			c1_s2 <= c1;
			mz_s2 <= mz_s1;
		end
		if (en[2]) c2_s3 <= c2;
		if (en[3]) ch_s4 <= ch;
	end

	assign vld   = vld_q;
	assign red   = ch_s4[0];
	assign green = ch_s4[1];
	assign blue  = ch_s4[2];
endmodule

FILE: src/cubemap_sky_gradient_texel.sv
// Sky gradient texel generator: top level with stage handshake and checks.
//
// pix_in carries one texel beat (face, texel_x, texel_y); pix_out returns one
// RGBA beat per texel, in order, alpha always 255. cfg writes face_size, the
// edge length in texels of a face.
// The datapath is a 23-stage pipeline: coordinate prep, reciprocal multiply,
// correction, sum of squares, nine square-root stages (two bits each, one in
// the last), six divider stages (three quotient bits each, two in the last),
// then weight select, blend, blend and byte conversion into the output
// register. Throughput is one texel per cycle while pix_out is ready and no
// face_size write is pending or in progress.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on pix_out fills bubbles first and then holds every stage; no beat
// is lost or repeated.
// A face_size write is taken only with the pipeline empty and starts a
// serial reciprocal of the size; pix_in is held off until it ends.
// Reset clears all valid bits and loads a face size of 256 with its
// reciprocal ready, so texels are accepted right after reset.
`include "cubemap_sky_gradient_texel_defines.svh"

module cubemap_sky_gradient_texel #(
	parameter int MAX_FACE_SIZE = csg_pkg::DEFAULT_MAX_FACE_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	csg_in_if.sink            pix_in,
	csg_out_if.source         pix_out,
	csg_cfg_if.sink           cfg
);
	import csg_pkg::*;

	localparam int N2_W = QMAG_W + FRAC;
	localparam logic [39:0] RECIP_NUM = 40'(1) << RECIP_SHIFT;

	recip_stat_t      stat;
	logic [NST-1:0]   vld;
	logic [NST-1:0]   en;
	logic             acc;
	logic             cfg_we;
	root_t            root_d [ROOT_STAGES+1];
	quo_t             quo_d [DIV_STAGES+1];
	logic [LEN_W-1:0] len;
	logic [N2_W-1:0]  n2;
	logic [39:0]      recip_prod;
	logic [39:0]      recip_next;

	// Stage i moves when it is empty or stage i+1 moves.
	always_comb begin
		en[NST-1] = !vld[NST-1] || pix_out.ready;
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = !vld[i] || en[i+1];
		end
	end

	assign pix_in.ready = en[0] && !stat.busy && !cfg.valid;
	assign acc          = pix_in.valid && pix_in.ready;
	assign cfg.ready    = !stat.busy && (vld == '0);
	assign cfg_we       = cfg.valid && cfg.ready;

	csg_recip #(.MAX_FACE_SIZE(MAX_FACE_SIZE)) u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.wdata  (cfg.face_size),
		.stat   (stat)
	);

	csg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[FRONT_STAGES-1:0]),
		.acc      (acc),
		.face     (pix_in.face),
		.texel_x  (pix_in.texel_x),
		.texel_y  (pix_in.texel_y),
		.stat     (stat),
		.vld      (vld[FRONT_STAGES-1:0]),
		.out_root (root_d[0])
	);

	for (genvar m = 0; m < ROOT_STAGES; m++) begin : g_root
		csg_root_stage #(.FIRST_J(ROOT_TOP_J - ROOT_STEPS * m)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en[ROOT_BASE+m]),
			.in_vld   (vld[ROOT_BASE+m-1]),
			.in_root  (root_d[m]),
			.vld      (vld[ROOT_BASE+m]),
			.out_root (root_d[m+1])
		);
	end

	// Numerator |comp| * 2^16 + len/2; its top bits seed the remainder.
	assign len = root_d[ROOT_STAGES].r[LEN_W-1:0];
	assign n2  = {root_d[ROOT_STAGES].comp_mag, FRAC'(0)} + N2_W'(len >> 1);

	assign quo_d[0].neg  = root_d[ROOT_STAGES].comp_neg;
	assign quo_d[0].len  = len;
	assign quo_d[0].rem  = LEN_W'(n2[N2_W-1:LEN_W]);
	assign quo_d[0].nlow = n2[LEN_W-1:0];
	assign quo_d[0].q    = '0;

	for (genvar m = 0; m < DIV_STAGES; m++) begin : g_div
		csg_div_stage #(.FIRST_I(DIV_TOP_I - DIV_STEPS * m)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en[DIV_BASE+m]),
			.in_vld  (vld[DIV_BASE+m-1]),
			.in_quo  (quo_d[m]),
			.vld     (vld[DIV_BASE+m]),
			.out_quo (quo_d[m+1])
		);
	end

	csg_shade u_shade (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en[NST-1:SHADE_BASE]),
		.in_vld (vld[SHADE_BASE-1]),
		.in_quo (quo_d[DIV_STAGES]),
		.vld    (vld[NST-1:SHADE_BASE]),
		.red    (pix_out.red),
		.green  (pix_out.green),
		.blue   (pix_out.blue)
	);

	assign pix_out.valid = vld[NST-1];
	assign pix_out.alpha = ALPHA_OPAQUE;

	assign recip_prod = 40'(stat.recip) * 40'(stat.size);
	assign recip_next = recip_prod + 40'(stat.size);

	`CSG_CHECK(a_idle_while_busy, stat.busy, vld == '0)
	`CSG_CHECK_NEXT(a_cfg_starts_recip, cfg.valid && cfg.ready, stat.busy)
	`CSG_CHECK(a_recip_exact, $fell(stat.busy), (recip_prod <= RECIP_NUM) && (recip_next > RECIP_NUM))
	`CSG_CHECK(a_quot_range, vld[SHADE_BASE-1], quo_d[DIV_STAGES].q <= QMAG_W'(ONE))
endmodule
